FILE: src/kcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared widths, item kinds, configuration indexes and reset values, key phases
// and event codes of the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

    // field widths fixed by the interface
    localparam int PinBits   = 4;
    localparam int KeySelW   = 2;
    localparam int EventW    = 2;
    localparam int CountW    = 16;
    localparam int PhaseW    = 3;
    localparam int CfgIndexW = 1;

    typedef logic [PhaseW-1:0]  t_phase;
    typedef logic [CountW-1:0]  t_count;
    typedef logic [EventW-1:0]  t_event;
    typedef logic [KeySelW-1:0] t_key_sel;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_LONG_PRESS   = 1'b0;
    localparam logic [CfgIndexW-1:0] CFG_DOUBLE_CLICK = 1'b1;

    // reset values of the configuration registers
    localparam t_count LONG_PRESS_RESET   = 16'd100;
    localparam t_count DOUBLE_CLICK_RESET = 16'd30;

    // per-key phase codes
    localparam t_phase PH_IDLE     = 3'd0;
    localparam t_phase PH_DEBOUNCE = 3'd1;
    localparam t_phase PH_HELD     = 3'd2;
    localparam t_phase PH_RELEASED = 3'd3;
    localparam t_phase PH_SECOND   = 3'd4;
    localparam t_phase PH_WAIT_REL = 3'd5;

    // event codes
    localparam t_event EV_NONE   = 2'd0;
    localparam t_event EV_SHORT  = 2'd1;
    localparam t_event EV_LONG   = 2'd2;
    localparam t_event EV_DOUBLE = 2'd3;

endpackage

FILE: src/key_click_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_classifier_top
// Per-key short, long and double click classifier for active-low buttons.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while input stall is low. A scan
// tick carries the pin levels of all keys and advances every key's phase
// machine at once; a read returns the latched event of one key and clears it.
// Each transaction is held in the input register, where the key machines and
// the event select work on it, and a read's result then lands in the output
// register, from which it drives the result channel. Ticks produce no result.
// Input stall rises only while a read waits behind a result that the
// downstream side is still stalling.
module key_click_classifier_top #(
    parameter int NUM_KEYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [kcc_pkg::PinBits-1:0]   i_pin_levels,
    input  logic [kcc_pkg::KeySelW-1:0]   i_key_select,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [kcc_pkg::EventW-1:0]    o_event_code,
    output logic [kcc_pkg::KeySelW-1:0]   o_event_key,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kcc_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [kcc_pkg::CountW-1:0]    i_cfg_data
);

    // configuration registers
    kcc_pkg::t_count r_long_press;
    kcc_pkg::t_count r_double_click;

    // input register
    logic                          r_in_valid;
    logic                          r_in_kind;
    logic [kcc_pkg::PinBits-1:0]   r_in_pins;
    kcc_pkg::t_key_sel             r_in_sel;

    // result register
    logic                          r_out_valid;
    kcc_pkg::t_event               r_out_code;
    kcc_pkg::t_key_sel             r_out_key;

    // per-key state
    kcc_pkg::t_phase r_phase   [NUM_KEYS];
    kcc_pkg::t_count r_count   [NUM_KEYS];
    kcc_pkg::t_event r_pending [NUM_KEYS];
    kcc_pkg::t_phase n_phase   [NUM_KEYS];
    kcc_pkg::t_count n_count   [NUM_KEYS];
    kcc_pkg::t_event n_pending [NUM_KEYS];

    logic            out_free;
    logic            in_advance;
    logic            do_tick;
    logic            do_read;
    logic            in_take;
    kcc_pkg::t_event read_code;

    // handshake between the two registers
    assign out_free   = !r_out_valid || !i_stall;
    assign in_advance = r_in_valid && ((r_in_kind == kcc_pkg::KIND_TICK) || out_free);
    assign do_tick    = in_advance && (r_in_kind == kcc_pkg::KIND_TICK);
    assign do_read    = in_advance && (r_in_kind == kcc_pkg::KIND_READ);
    assign o_stall    = r_in_valid && !in_advance;
    assign in_take    = i_valid && !o_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_code;
    assign o_event_key  = r_out_key;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press   <= kcc_pkg::LONG_PRESS_RESET;
            r_double_click <= kcc_pkg::DOUBLE_CLICK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kcc_pkg::CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                kcc_pkg::CFG_DOUBLE_CLICK: r_double_click <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= i_kind;
            r_in_pins <= i_pin_levels;
            r_in_sel  <= i_key_select;
        end
    end

    // event select of the read key, zero when the key does not exist
    always_comb begin
        read_code = kcc_pkg::EV_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (int'(r_in_sel) == k) begin
                read_code = r_pending[k];
            end
        end
    end

    // per-key phase machines
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic            pressed;
        kcc_pkg::t_count count_inc;

        if (k < kcc_pkg::PinBits) begin : g_pin
            assign pressed = !r_in_pins[k];
        end else begin : g_no_pin
            assign pressed = 1'b0;
        end

        assign count_inc = r_count[k] + kcc_pkg::CountW'(1);

        always_comb begin
            n_phase[k]   = r_phase[k];
            n_count[k]   = r_count[k];
            n_pending[k] = r_pending[k];
            if (do_tick) begin
                unique case (r_phase[k])
                    kcc_pkg::PH_DEBOUNCE: begin
                        if (pressed) begin
                            n_phase[k] = kcc_pkg::PH_HELD;
                            n_count[k] = '0;
                        end else begin
                            n_phase[k] = kcc_pkg::PH_IDLE;
                        end
                    end
                    kcc_pkg::PH_HELD: begin
                        if (pressed) begin
                            n_count[k] = count_inc;
                            if (count_inc >= r_long_press) begin
                                n_pending[k] = kcc_pkg::EV_LONG;
                                n_phase[k]   = kcc_pkg::PH_WAIT_REL;
                            end
                        end else begin
                            n_count[k] = '0;
                            n_phase[k] = kcc_pkg::PH_RELEASED;
                        end
                    end
                    kcc_pkg::PH_RELEASED: begin
                        if (pressed) begin
                            n_phase[k] = kcc_pkg::PH_SECOND;
                        end else begin
                            n_count[k] = count_inc;
                            if (count_inc >= r_double_click) begin
                                n_pending[k] = kcc_pkg::EV_SHORT;
                                n_phase[k]   = kcc_pkg::PH_IDLE;
                            end
                        end
                    end
                    kcc_pkg::PH_SECOND: begin
                        if (pressed) begin
                            n_pending[k] = kcc_pkg::EV_DOUBLE;
                            n_phase[k]   = kcc_pkg::PH_WAIT_REL;
                        end else begin
                            n_phase[k] = kcc_pkg::PH_RELEASED;
                        end
                    end
                    kcc_pkg::PH_WAIT_REL: begin
                        if (!pressed) begin
                            n_phase[k] = kcc_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        // idle and the unused codes
                        if (pressed) begin
                            n_phase[k] = kcc_pkg::PH_DEBOUNCE;
                            n_count[k] = '0;
                        end else begin
                            n_phase[k] = kcc_pkg::PH_IDLE;
                        end
                    end
                endcase
            end else if (do_read && (int'(r_in_sel) == k)) begin
                n_pending[k] = kcc_pkg::EV_NONE;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_phase[k]   <= kcc_pkg::PH_IDLE;
                r_count[k]   <= '0;
                r_pending[k] <= kcc_pkg::EV_NONE;
            end else begin
                r_phase[k]   <= n_phase[k];
                r_count[k]   <= n_count[k];
                r_pending[k] <= n_pending[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= do_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_out_code <= read_code;
            r_out_key  <= r_in_sel;
        end
    end

endmodule

FILE: src/kcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks of the key click classifier, bound to the top level.
// ----------------------------------------------------------------------------
module kcc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic                          i_kind,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [kcc_pkg::EventW-1:0]    o_event_code,
    input  logic [kcc_pkg::KeySelW-1:0]   o_event_key
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a new result only follows an accepted read, through the input and result registers
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |->
            $past(i_valid && !o_stall && (i_kind == kcc_pkg::KIND_READ), 2))
        else $error("result without an accepted read");

    // input stalls only while a result is blocked downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with result channel free");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_event_code) && $stable(o_event_key)))
        else $error("stalled result changed");

endmodule

bind key_click_classifier_top kcc_checker u_kcc_checker (.*);
